[sv/jpeg_header_validator_top_defines.svh]
// Assertion macros shared by the JPEG header validator modules.
`ifndef JPEG_HEADER_VALIDATOR_TOP_DEFINES_SVH
`define JPEG_HEADER_VALIDATOR_TOP_DEFINES_SVH
// Assert that a property holds at every clock edge outside reset.
`define JHV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
// Assert an implication that must hold on the following clock edge.
`define JHV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("assertion failed");
`endif

[sv/jhv_pkg.sv]
// Package with shared types, codes and helpers of the JPEG header validator.
`timescale 1ns / 1ps
package jhv_pkg;

  localparam logic [1:0] StOk  = 2'd0;
  localparam logic [1:0] StBad = 2'd1;
  localparam logic [1:0] StNs  = 2'd2;

  localparam logic [7:0] MkSoi   = 8'hd8;
  localparam logic [7:0] MkEoi   = 8'hd9;
  localparam logic [7:0] MkApp14 = 8'hee;
  localparam logic [7:0] MkSof0  = 8'hc0;
  localparam logic [7:0] MkDht   = 8'hc4;
  localparam logic [7:0] MkJpg   = 8'hc8;
  localparam logic [7:0] MkDac   = 8'hcc;
  localparam logic [7:0] MkSos   = 8'hda;
  localparam logic [7:0] MkRst0  = 8'hd0;
  localparam logic [7:0] MkFill  = 8'hff;
  localparam logic [7:0] SpecEnd = 8'd63;
  localparam logic [7:0] IdR = 8'h52;
  localparam logic [7:0] IdG = 8'h47;
  localparam logic [7:0] IdB = 8'h42;

  // Command from the controller to the datapath for the current byte.
  typedef enum logic [3:0] {
    CmdNone,
    CmdStart,
    CmdMarker,
    CmdLenHi,
    CmdLenLo,
    CmdBody,
    CmdSettle
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] status;
  } jhv_ctrl_t;

  // Status from the datapath, computed on the current byte.
  typedef struct packed {
    logic        len_short;    // fewer than two bytes left after the marker
    logic        seg_bad;      // length below 2 or past the stream end
    logic        seg_empty;    // segment has no body
    logic        last_byte;    // current byte is the stream's last
    logic        body_done;    // this body byte ends the segment
    logic        body_valid;   // body result is decided
    logic [1:0]  body_status;
    logic        frame_seen;
    logic        scan_seen;
    logic        len_tiny;     // stream length too short for any header
    logic [1:0]  eoi_status;
    logic [15:0] seg_size;
  } jhv_stat_t;

  function automatic logic [7:0] adobe_char(input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (idx)
      3'd0: c = 8'h41;
      3'd1: c = 8'h64;
      3'd2: c = 8'h6f;
      3'd3: c = 8'h62;
      3'd4: c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Ratio code of luma to chroma factors, zero when not supported.
  function automatic logic [2:0] ratio_code(input logic [2:0] yf, input logic [2:0] cf);
    logic [2:0] r;
    r = 3'd0;
    if (yf == cf) r = 3'd1;
    else if (yf == {cf[1:0], 1'b0} && cf != 3'd0) r = 3'd2;
    return r;
  endfunction

endpackage

[sv/jhv_stream_if.sv]
// Valid/ready channel interfaces of the JPEG header validator.
`timescale 1ns / 1ps
interface jhv_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] stream_length;
  modport source (output valid, output data_byte, output stream_length, input ready);
  modport sink (input valid, input data_byte, input stream_length, output ready);
endinterface

interface jhv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [1:0]  component_count;
  logic [2:0]  chroma_code;
  logic [31:0] kept_length;
  modport source (output valid, output status, output image_width, output image_height,
                  output component_count, output chroma_code, output kept_length,
                  input ready);
  modport sink (input valid, input status, input image_width, input image_height,
                input component_count, input chroma_code, input kept_length,
                output ready);
endinterface

[sv/jhv_datapath.sv]
// Datapath: byte counters, segment registers, frame and scan field checks.
`timescale 1ns / 1ps
`include "jpeg_header_validator_top_defines.svh"
module jhv_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         byte_i,
  input  logic [31:0]        len_i,
  input  jhv_pkg::jhv_ctrl_t ctrl_i,
  output jhv_pkg::jhv_stat_t stat_o,
  output logic [1:0]         res_status_o,
  output logic [15:0]        res_width_o,
  output logic [15:0]        res_height_o,
  output logic [1:0]         res_comp_o,
  output logic [2:0]         res_chroma_o,
  output logic [31:0]        res_kept_o
);

  logic [31:0] pos_q, pos_d, total_q, total_d, remain_q, remain_d;
  logic [7:0]  marker_q, marker_d;
  logic [15:0] size_q, size_d, off_q, off_d;
  logic        frame_q, frame_d, scan_q, scan_d, adobe_q, adobe_d, tagok_q, tagok_d;
  logic [7:0]  adobe_val_q, adobe_val_d;
  logic [15:0] width_q, width_d, height_q, height_d;
  logic [1:0]  comps_q, comps_d;
  logic [7:0]  ids_q [3];
  logic [7:0]  samp_q [3];
  logic [2:0]  chroma_q, chroma_d;
  // Frame component index and phase within its three-byte group.
  logic [1:0]  fk_q, fk_d, fr_q, fr_d;

  logic [31:0] pos_n, remain_n;
  logic        wr_id, wr_samp;
  logic [1:0]  bstat;
  logic        bvalid, bdone;
  logic [15:0] off_n;
  logic [15:0] sos_n2;
  logic [2:0]  yh, yv, ch, cv, rh, rv;
  logic [1:0]  sos_c;
  logic [2:0]  chroma_calc;
  logic        chroma_ns;
  logic [1:0]  eoi_st;
  logic [7:0]  hi_n, lo_n;

  // Position of the current byte and bytes left after it.
  always_comb begin
    if (ctrl_i.cmd == jhv_pkg::CmdStart) begin
      pos_n    = 32'd1;
      remain_n = len_i - 32'd1;
    end else begin
      pos_n    = pos_q + 32'd1;
      remain_n = remain_q - 32'd1;
    end
  end

  // Chroma derivation from the luma and the first chroma sampling bytes.
  always_comb begin
    yh = samp_q[0][6:4]; yv = samp_q[0][2:0];
    ch = byte_i[6:4];    cv = byte_i[2:0];
    rh = jhv_pkg::ratio_code(yh, ch);
    rv = jhv_pkg::ratio_code(yv, cv);
    chroma_ns = 1'b0;
    chroma_calc = 3'd0;
    if ((ids_q[0] == jhv_pkg::IdR && ids_q[1] == jhv_pkg::IdG && ids_q[2] == jhv_pkg::IdB)
        || samp_q[1] != byte_i || rh == 3'd0 || rv == 3'd0) begin
      chroma_ns = 1'b1;
    end else begin
      unique case ({rh[1], rv[1]})
        2'b00: chroma_calc = 3'd1;
        2'b01: chroma_calc = 3'd2;
        2'b10: chroma_calc = 3'd3;
        2'b11: chroma_calc = 3'd4;
        default: chroma_calc = 3'd0;
      endcase
    end
  end

  // Body byte evaluation for the current marker.
  always_comb begin
    hi_n = byte_i >> 4;
    lo_n = byte_i & 8'h0f;
    bvalid = 1'b0; bstat = jhv_pkg::StOk;
    wr_id = 1'b0; wr_samp = 1'b0;
    sos_n2 = {13'd0, comps_q, 1'b0};
    sos_c = 2'(({8'd0, off_q} - 16'd1) >> 1);
    if (marker_q == jhv_pkg::MkSof0) begin
      if (off_q == 16'd0) begin
        if (byte_i != 8'd8) begin bvalid = 1'b1; bstat = jhv_pkg::StNs; end
      end else if (off_q == 16'd5) begin
        if (width_q == 16'd0 || height_q == 16'd0) begin
          bvalid = 1'b1; bstat = jhv_pkg::StBad;
        end else if (byte_i != 8'd1 && byte_i != 8'd3) begin
          bvalid = 1'b1; bstat = jhv_pkg::StNs;
        end else if (size_q != 16'd8 + 16'd3 * {8'd0, byte_i}) begin
          bvalid = 1'b1; bstat = jhv_pkg::StBad;
        end
      end else if (off_q > 16'd5 && {1'b0, fk_q} < {1'b0, comps_q} && fk_q != 2'd3) begin
        if (fr_q == 2'd0) wr_id = 1'b1;
        else if (fr_q == 2'd1) begin
          wr_samp = 1'b1;
          if (hi_n == 8'd0 || lo_n == 8'd0 || hi_n > 8'd4 || lo_n > 8'd4) begin
            bvalid = 1'b1; bstat = jhv_pkg::StBad;
          end else if ((fk_q >= 2'd1 && ids_q[0] == ids_q[fk_q]) ||
                       (fk_q == 2'd2 && ids_q[1] == ids_q[2])) begin
            bvalid = 1'b1; bstat = jhv_pkg::StBad;
          end else if (fk_q + 2'd1 == comps_q && comps_q == 2'd3 && chroma_ns) begin
            bvalid = 1'b1; bstat = jhv_pkg::StNs;
          end
        end
      end
    end else if (marker_q == jhv_pkg::MkSos) begin
      if (off_q == 16'd0) begin
        if (byte_i != {6'd0, comps_q}) begin bvalid = 1'b1; bstat = jhv_pkg::StNs; end
        else if (size_q != 16'd6 + sos_n2) begin bvalid = 1'b1; bstat = jhv_pkg::StBad; end
      end else if (off_q <= sos_n2) begin
        if (off_q[0] && sos_c != 2'd3 && byte_i != ids_q[sos_c]) begin
          bvalid = 1'b1; bstat = jhv_pkg::StNs;
        end
      end else if (off_q == sos_n2 + 16'd1 || off_q == sos_n2 + 16'd3) begin
        if (byte_i != 8'd0) begin bvalid = 1'b1; bstat = jhv_pkg::StNs; end
      end else if (off_q == sos_n2 + 16'd2) begin
        if (byte_i != jhv_pkg::SpecEnd) begin bvalid = 1'b1; bstat = jhv_pkg::StNs; end
      end
    end
    off_n = off_q + 16'd1;
    bdone = ({1'b0, off_n} + 17'd2) >= {1'b0, size_q};
  end

  // Outcome at EOI.
  always_comb begin
    if (!frame_q || !scan_q) eoi_st = jhv_pkg::StBad;
    else if (comps_q == 2'd3 && adobe_q && adobe_val_q != 8'd1) eoi_st = jhv_pkg::StNs;
    else eoi_st = jhv_pkg::StOk;
  end

  // Status toward the controller.
  always_comb begin
    stat_o.len_short   = remain_n < 32'd2;
    stat_o.seg_bad     = ({size_q[15:8], byte_i} < 16'd2) ||
                         ({17'd0, size_q[15:8], byte_i} > {1'b0, remain_n} + 33'd2);
    stat_o.seg_empty   = {size_q[15:8], byte_i} == 16'd2;
    stat_o.last_byte   = ctrl_i.cmd == jhv_pkg::CmdStart ? len_i <= 32'd1
                                                          : remain_q <= 32'd1;
    stat_o.body_done   = bdone;
    stat_o.body_valid  = bvalid;
    stat_o.body_status = bstat;
    stat_o.frame_seen  = frame_q;
    stat_o.scan_seen   = scan_q;
    stat_o.len_tiny    = len_i < 32'd4;
    stat_o.eoi_status  = eoi_st;
    stat_o.seg_size    = {size_q[15:8], byte_i};
  end

  // Next register values.
  always_comb begin
    pos_d = pos_q; total_d = total_q; remain_d = remain_q;
    marker_d = marker_q; size_d = size_q; off_d = off_q;
    frame_d = frame_q; scan_d = scan_q; adobe_d = adobe_q; tagok_d = tagok_q;
    adobe_val_d = adobe_val_q; width_d = width_q; height_d = height_q;
    comps_d = comps_q; chroma_d = chroma_q; fk_d = fk_q; fr_d = fr_q;
    if (accept_i) begin
      pos_d = pos_n; remain_d = remain_n;
      unique case (ctrl_i.cmd)
        jhv_pkg::CmdStart: begin
          total_d = len_i; marker_d = 8'd0; size_d = 16'd0; off_d = 16'd0;
          frame_d = 1'b0; scan_d = 1'b0; adobe_d = 1'b0; tagok_d = 1'b0;
          adobe_val_d = 8'd0; width_d = 16'd0; height_d = 16'd0;
          comps_d = 2'd0; chroma_d = 3'd0;
        end
        jhv_pkg::CmdMarker: marker_d = byte_i;
        jhv_pkg::CmdLenHi:  size_d = {byte_i, 8'd0};
        jhv_pkg::CmdLenLo: begin
          size_d = {size_q[15:8], byte_i};
          off_d = 16'd0; fk_d = 2'd0; fr_d = 2'd0;
          if (marker_q == jhv_pkg::MkApp14) tagok_d = 1'b1;
        end
        jhv_pkg::CmdBody: begin
          if (marker_q == jhv_pkg::MkApp14) begin
            if (off_q < 16'd5 && byte_i != jhv_pkg::adobe_char(off_q[2:0])) tagok_d = 1'b0;
            if (off_q == 16'd11 && size_q >= 16'd14 && tagok_q) begin
              adobe_d = 1'b1; adobe_val_d = byte_i;
            end
          end else if (marker_q == jhv_pkg::MkSof0) begin
            if (off_q == 16'd1) height_d = {byte_i, height_q[7:0]};
            if (off_q == 16'd2) height_d = {height_q[15:8], byte_i};
            if (off_q == 16'd3) width_d = {byte_i, width_q[7:0]};
            if (off_q == 16'd4) width_d = {width_q[15:8], byte_i};
            if (off_q == 16'd5) comps_d = byte_i[1:0];
            if (off_q >= 16'd6) begin
              if (fr_q == 2'd2) begin
                fr_d = 2'd0;
                if (fk_q != 2'd3) fk_d = fk_q + 2'd1;
              end else fr_d = fr_q + 2'd1;
            end
            if (wr_samp && !bvalid && fk_q + 2'd1 == comps_q) begin
              chroma_d = comps_q == 2'd1 ? 3'd5 : chroma_calc;
              frame_d = 1'b1;
            end
          end
          if (!bvalid) begin
            off_d = off_n;
            if (bdone && marker_q == jhv_pkg::MkSos) scan_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 32'd0; total_q <= 32'd0; remain_q <= 32'd0;
      marker_q <= 8'd0; size_q <= 16'd0; off_q <= 16'd0;
      frame_q <= 1'b0; scan_q <= 1'b0; adobe_q <= 1'b0; tagok_q <= 1'b0;
      adobe_val_q <= 8'd0; width_q <= 16'd0; height_q <= 16'd0;
      comps_q <= 2'd0; chroma_q <= 3'd0; fk_q <= 2'd0; fr_q <= 2'd0;
    end else begin
      pos_q <= pos_d; total_q <= total_d; remain_q <= remain_d;
      marker_q <= marker_d; size_q <= size_d; off_q <= off_d;
      frame_q <= frame_d; scan_q <= scan_d; adobe_q <= adobe_d; tagok_q <= tagok_d;
      adobe_val_q <= adobe_val_d; width_q <= width_d; height_q <= height_d;
      comps_q <= comps_d; chroma_q <= chroma_d; fk_q <= fk_d; fr_q <= fr_d;
    end
  end

  // Component identifiers and sampling bytes, written by the frame header.
  always_ff @(posedge clk_i) begin
    if (accept_i && ctrl_i.cmd == jhv_pkg::CmdBody && wr_id) ids_q[fk_q] <= byte_i;
    if (accept_i && ctrl_i.cmd == jhv_pkg::CmdBody && wr_samp) samp_q[fk_q] <= byte_i;
  end

  // Result fields; the geometry is zero unless the stream succeeded.
  always_comb begin
    res_status_o = ctrl_i.status;
    if (ctrl_i.status == jhv_pkg::StOk) begin
      res_width_o  = width_q;
      res_height_o = height_q;
      res_comp_o   = comps_q;
      res_chroma_o = chroma_q;
      res_kept_o   = pos_n;
    end else begin
      res_width_o = 16'd0; res_height_o = 16'd0; res_comp_o = 2'd0;
      res_chroma_o = 3'd0; res_kept_o = 32'd0;
    end
  end

  `JHV_ASSERT(a_pos_total, clk_i, rst_ni, pos_q + remain_q == total_q || pos_q == 32'd0)
  `JHV_ASSERT(a_scan_frame, clk_i, rst_ni, !scan_q || frame_q)
  `JHV_ASSERT_NEXT(a_start_pos, clk_i, rst_ni, accept_i && ctrl_i.cmd == jhv_pkg::CmdStart,
                   pos_q == 32'd1)

endmodule

[sv/jhv_controller.sv]
// Controller: parse phase state machine and result output register.
`timescale 1ns / 1ps
`include "jpeg_header_validator_top_defines.svh"
module jhv_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         byte_i,
  input  jhv_pkg::jhv_stat_t stat_i,
  output jhv_pkg::jhv_ctrl_t ctrl_o,
  output logic               accept_o,
  output logic               res_load_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);

  typedef enum logic [3:0] {
    PhIdle, PhSoi2, PhMark, PhFill, PhLenHi, PhLenLo, PhBody, PhEnt, PhEntFill, PhDiscard
  } phase_e;

  phase_e     phase_q, phase_d;
  logic       ovalid_q, ovalid_d;
  logic       res;
  logic [1:0] rst_code;
  // Marker byte tracked here to decide segment-level checks.
  logic [7:0] cur_marker_q;

  function automatic logic marker_is_sof(input logic [7:0] m);
    return m >= 8'hc0 && m <= 8'hcf && m != jhv_pkg::MkDht &&
           m != jhv_pkg::MkJpg && m != jhv_pkg::MkDac;
  endfunction

  // Input is taken whenever the result register is free to take a result.
  assign in_ready_o = !ovalid_q || out_ready_i;
  assign accept_o   = in_valid_i && in_ready_o;

  // Phase decode of the current byte.
  always_comb begin
    phase_d = phase_q;
    res = 1'b0;
    rst_code = jhv_pkg::StBad;
    ctrl_o.cmd = jhv_pkg::CmdNone;
    unique case (phase_q)
      PhIdle: begin
        ctrl_o.cmd = jhv_pkg::CmdStart;
        if (stat_i.last_byte || stat_i.len_tiny || byte_i != jhv_pkg::MkFill) res = 1'b1;
        else phase_d = PhSoi2;
      end
      PhSoi2: if (byte_i != jhv_pkg::MkSoi) res = 1'b1; else phase_d = PhMark;
      PhMark: if (byte_i != jhv_pkg::MkFill) res = 1'b1; else phase_d = PhFill;
      PhFill: begin
        if (byte_i != jhv_pkg::MkFill) begin
          ctrl_o.cmd = jhv_pkg::CmdMarker;
          if (byte_i == jhv_pkg::MkEoi) begin
            res = 1'b1; rst_code = stat_i.eoi_status;
          end else if (byte_i == 8'd0 || byte_i == jhv_pkg::MkSoi ||
                       (byte_i >= jhv_pkg::MkRst0 && byte_i <= 8'hd7)) begin
            res = 1'b1;
          end else if (stat_i.len_short) res = 1'b1;
          else phase_d = PhLenHi;
        end
      end
      PhLenHi: begin ctrl_o.cmd = jhv_pkg::CmdLenHi; phase_d = PhLenLo; end
      PhLenLo: begin
        ctrl_o.cmd = jhv_pkg::CmdLenLo;
        phase_d = stat_i.seg_empty ? PhMark : PhBody;
        if (stat_i.seg_bad) res = 1'b1;
        else if (marker_is_sof(cur_marker_q)) begin
          if (cur_marker_q != jhv_pkg::MkSof0) begin res = 1'b1; rst_code = jhv_pkg::StNs; end
          else if (stat_i.frame_seen || stat_i.seg_size < 16'd8) res = 1'b1;
        end else if (cur_marker_q == jhv_pkg::MkSos) begin
          if (!stat_i.frame_seen || stat_i.scan_seen || stat_i.seg_size < 16'd6) res = 1'b1;
        end
      end
      PhBody: begin
        ctrl_o.cmd = jhv_pkg::CmdBody;
        if (stat_i.body_valid) begin res = 1'b1; rst_code = stat_i.body_status; end
        else if (stat_i.body_done)
          phase_d = cur_marker_q == jhv_pkg::MkSos ? PhEnt : PhMark;
      end
      PhEnt: if (byte_i == jhv_pkg::MkFill) phase_d = PhEntFill;
      PhEntFill: begin
        if (byte_i != jhv_pkg::MkFill) begin
          if (byte_i == 8'd0 || (byte_i >= jhv_pkg::MkRst0 && byte_i <= 8'hd7)) phase_d = PhEnt;
          else if (byte_i == jhv_pkg::MkEoi) begin
            res = 1'b1; rst_code = stat_i.eoi_status;
          end else begin res = 1'b1; rst_code = jhv_pkg::StNs; end
        end
      end
      PhDiscard: ;
      default: ;
    endcase
    // Stream exhausted without a decision.
    if (!res && phase_q != PhDiscard && stat_i.last_byte) begin
      res = 1'b1; rst_code = jhv_pkg::StBad;
    end
    if (res) phase_d = PhDiscard;
    if (stat_i.last_byte) phase_d = PhIdle;
    ctrl_o.status = rst_code;
  end

  assign res_load_o = accept_o && res;

  always_comb begin
    ovalid_d = ovalid_q;
    if (out_ready_i) ovalid_d = 1'b0;
    if (res_load_o) ovalid_d = 1'b1;
  end
  assign out_valid_o = ovalid_q;

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      ovalid_q <= 1'b0;
      cur_marker_q <= 8'd0;
    end else begin
      ovalid_q <= ovalid_d;
      if (accept_o) begin
        phase_q <= phase_d;
        if (ctrl_o.cmd == jhv_pkg::CmdMarker) cur_marker_q <= byte_i;
        if (ctrl_o.cmd == jhv_pkg::CmdStart) cur_marker_q <= 8'd0;
      end
    end
  end

  `JHV_ASSERT_NEXT(a_res_valid, clk_i, rst_ni, res_load_o, out_valid_o)
  `JHV_ASSERT(a_stall_no_take, clk_i, rst_ni, !(out_valid_o && !out_ready_i) || !in_ready_o)
  `JHV_ASSERT_NEXT(a_res_discard, clk_i, rst_ni, res_load_o && !stat_i.last_byte,
                   phase_q == PhDiscard)

endmodule

[sv/jpeg_header_validator_top.sv]
// Top level of the byte-serial JPEG baseline header validator.
// Usage: feed a JPEG stream on in_ch one byte per transaction; each byte
// carries the stream's total length, which is sampled on the first byte.
// One result per stream appears on out_ch: status, geometry and the count
// of bytes kept through EOI (geometry and count are zero unless status is
// success). Bytes that follow the deciding byte are consumed and dropped
// until the stream length is used up; the next byte starts a new stream.
// Throughput: one byte per cycle unless a held result stalls in_ch; every
// byte is checked in the cycle it is accepted by the phase state machine
// and the segment datapath. The result is registered and shows on out_ch
// in the cycle after the deciding byte is accepted.
// The result register holds one transaction; while it waits and the sink
// stalls, in_ch ready is low, and it rises again in the cycle the result
// is taken.
// Reset: asynchronous, active low; it returns the parser to waiting for the
// first byte of a stream and drops any pending result.
`timescale 1ns / 1ps
module jpeg_header_validator_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  jhv_in_if.sink    in_ch,
  jhv_out_if.source out_ch
);

  jhv_pkg::jhv_ctrl_t ctrl;
  jhv_pkg::jhv_stat_t stat;
  logic        accept, res_load;
  logic [1:0]  r_status, r_comp;
  logic [15:0] r_width, r_height;
  logic [2:0]  r_chroma;
  logic [31:0] r_kept;
  logic [1:0]  status_q, comp_q;
  logic [15:0] width_q, height_q;
  logic [2:0]  chroma_q;
  logic [31:0] kept_q;

  jhv_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .byte_i(in_ch.data_byte),
    .stat_i(stat), .ctrl_o(ctrl), .accept_o(accept), .res_load_o(res_load),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready)
  );

  jhv_datapath u_dp (
    .clk_i, .rst_ni, .accept_i(accept), .byte_i(in_ch.data_byte),
    .len_i(in_ch.stream_length), .ctrl_i(ctrl), .stat_o(stat),
    .res_status_o(r_status), .res_width_o(r_width), .res_height_o(r_height),
    .res_comp_o(r_comp), .res_chroma_o(r_chroma), .res_kept_o(r_kept)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q <= r_status; width_q <= r_width; height_q <= r_height;
      comp_q <= r_comp; chroma_q <= r_chroma; kept_q <= r_kept;
    end
  end

  assign out_ch.status          = status_q;
  assign out_ch.image_width     = width_q;
  assign out_ch.image_height    = height_q;
  assign out_ch.component_count = comp_q;
  assign out_ch.chroma_code     = chroma_q;
  assign out_ch.kept_length     = kept_q;

endmodule
